FILE: hw/rtl/mvm_pkg.sv
// shared types and constants of the matrix-vector multiply block
package mvm_pkg;

  localparam int VALUE_W   = 16;
  localparam int PROD_W    = 32;
  localparam int DOT_W     = 48;
  localparam int ROW_W     = 16;
  localparam int COLS_W    = 15;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [COLS_W-1:0] COLS_RESET = COLS_W'(768);
  localparam logic [ROW_W-1:0]  ROWS_RESET = ROW_W'(768);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = CFG_IDX_W'(1);

  // item modes
  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_WEIGHT = 1'b1;

  // one operation handed from the sequencer to the mac stage
  typedef struct packed {
    logic                      valid;
    logic                      clear;
    logic signed [VALUE_W-1:0] value;
    logic                      end_row;
    logic [ROW_W-1:0]          row_index;
    logic                      last;
  } mvm_op_t;

endpackage

FILE: hw/rtl/mvm_if.sv
// handshake interfaces for the input, result and configuration channels
interface mvm_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  mode;
  logic signed [mvm_pkg::VALUE_W-1:0]    value;
  modport source (output valid, mode, value, input ready);
  modport sink (input valid, mode, value, output ready);
endinterface

interface mvm_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [mvm_pkg::DOT_W-1:0]      dot;
  logic [mvm_pkg::ROW_W-1:0]             row_index;
  logic                                  last_row;
  modport source (output valid, dot, row_index, last_row, input ready);
  modport sink (input valid, dot, row_index, last_row, output ready);
endinterface

interface mvm_cfg_if;
  logic                                  valid;
  logic                                  ready;
  logic [mvm_pkg::CFG_IDX_W-1:0]         index;
  logic [mvm_pkg::CFG_DATA_W-1:0]        data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/mvm_vmem.sv
// vector store: one write port, one read port, registered read data
module mvm_vmem #(
  parameter int AW = 14
) (
  input  logic                               clk,
  input  logic                               we,
  input  logic [AW-1:0]                      waddr,
  input  logic signed [mvm_pkg::VALUE_W-1:0] wdata,
  input  logic                               re,
  input  logic [AW-1:0]                      raddr,
  output logic signed [mvm_pkg::VALUE_W-1:0] rdata
);

  logic signed [mvm_pkg::VALUE_W-1:0] mem [2**AW];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/mvm_ctrl.sv
// sequencer: config registers, load pointer, column and row counters
module mvm_ctrl #(
  parameter int MAX_COLS = 16384,
  parameter int AW       = 14
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               advance,
  input  logic                               in_valid,
  input  logic                               in_mode,
  input  logic signed [mvm_pkg::VALUE_W-1:0] in_value,
  input  logic                               cfg_valid,
  input  logic [mvm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mvm_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                               mem_we,
  output logic [AW-1:0]                      mem_waddr,
  output logic                               mem_re,
  output logic [AW-1:0]                      mem_raddr,
  output mvm_pkg::mvm_op_t                   op
);

  localparam int CW = AW + 1;

  logic [mvm_pkg::COLS_W-1:0] cols;
  logic [mvm_pkg::ROW_W-1:0]  rows;
  logic [AW-1:0]              load_ptr;
  logic [AW-1:0]              col;
  logic [mvm_pkg::ROW_W-1:0]  row;

  logic [CW-1:0]              nc;
  logic [mvm_pkg::ROW_W-1:0]  nr_m1;
  logic                       accept;
  logic [AW-1:0]              wr_ptr;
  logic [CW-1:0]              wr_ptr_inc;
  logic [CW-1:0]              col_inc;
  logic                       end_row;
  logic                       last;

  // effective sizes
  always_comb begin
    if (cols == '0) begin
      nc = CW'(1);
    end else if (32'(cols) > 32'(MAX_COLS)) begin
      nc = CW'(MAX_COLS);
    end else begin
      nc = CW'(cols);
    end
    nr_m1 = (rows == '0) ? '0 : rows - 1'b1;
  end

  assign accept = advance && in_valid;

  // load pointer and column progress
  always_comb begin
    wr_ptr     = ({1'b0, load_ptr} >= nc) ? '0 : load_ptr;
    wr_ptr_inc = {1'b0, wr_ptr} + 1'b1;
    col_inc    = {1'b0, col} + 1'b1;
    end_row    = col_inc >= nc;
    last       = row >= nr_m1;
  end

  // memory access on accept
  assign mem_we    = accept && (in_mode == mvm_pkg::MODE_LOAD);
  assign mem_waddr = wr_ptr;
  assign mem_re    = accept && (in_mode == mvm_pkg::MODE_WEIGHT);
  assign mem_raddr = col;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cols <= mvm_pkg::COLS_RESET;
      rows <= mvm_pkg::ROWS_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        mvm_pkg::CFG_COLS: cols <= cfg_data[mvm_pkg::COLS_W-1:0];
        mvm_pkg::CFG_ROWS: rows <= cfg_data[mvm_pkg::ROW_W-1:0];
        default: ;
      endcase
    end
  end

  // counters and the operation register
  always_ff @(posedge clk) begin
    if (rst) begin
      load_ptr <= '0;
      col      <= '0;
      row      <= '0;
      op.valid <= 1'b0;
    end else if (advance) begin
      op.valid <= in_valid;
      if (in_valid) begin
        op.clear     <= (in_mode == mvm_pkg::MODE_LOAD);
        op.value     <= in_value;
        op.end_row   <= end_row;
        op.row_index <= row;
        op.last      <= last;
        if (in_mode == mvm_pkg::MODE_LOAD) begin
          load_ptr <= (wr_ptr_inc >= nc) ? '0 : wr_ptr_inc[AW-1:0];
          col      <= '0;
          row      <= '0;
        end else begin
          load_ptr <= '0;
          if (end_row) begin
            col <= '0;
            row <= last ? '0 : row + 1'b1;
          end else begin
            col <= col_inc[AW-1:0];
          end
        end
      end
    end
  end

endmodule

FILE: hw/rtl/mvm_mac.sv
// multiply stage, accumulator and result register
module mvm_mac (
  input  logic                               clk,
  input  logic                               rst,
  input  mvm_pkg::mvm_op_t                   op,
  input  logic signed [mvm_pkg::VALUE_W-1:0] xe,
  input  logic                               out_ready,
  output logic                               advance,
  output logic                               out_valid,
  output logic signed [mvm_pkg::DOT_W-1:0]   dot,
  output logic [mvm_pkg::ROW_W-1:0]          row_index,
  output logic                               last_row
);

  logic                              s2_valid;
  logic                              s2_clear;
  logic                              s2_end;
  logic [mvm_pkg::ROW_W-1:0]         s2_row;
  logic                              s2_last;
  logic signed [mvm_pkg::PROD_W-1:0] prod;
  logic signed [mvm_pkg::DOT_W-1:0]  acc;
  logic signed [mvm_pkg::DOT_W-1:0]  acc_sum;

  // whole pipeline moves unless a result is stuck
  assign advance = !out_valid || out_ready;

  assign acc_sum = acc + mvm_pkg::DOT_W'(prod);

  // multiply stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= op.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && op.valid) begin
      s2_clear <= op.clear;
      s2_end   <= op.end_row;
      s2_row   <= op.row_index;
      s2_last  <= op.last;
      prod     <= mvm_pkg::PROD_W'(op.value * xe);
    end
  end

  // accumulate and emit at the end of a row
  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s2_valid && !s2_clear && s2_end;
      if (s2_valid) begin
        if (s2_clear || s2_end) begin
          acc <= '0;
        end else begin
          acc <= acc_sum;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s2_valid && !s2_clear && s2_end) begin
      dot       <= acc_sum;
      row_index <= s2_row;
      last_row  <= s2_last;
    end
  end

endmodule

FILE: hw/rtl/matrix_vector_multiply.sv
// Streaming fixed-point matrix-vector multiply, top level
// The last weight of a row passes the op, multiply and result registers.
// Throughput: one item per cycle; input and pipeline hold while a result waits unread.
// The vector store has one write and one read port, one multiply-accumulate per cycle.
// Reset: counters, accumulator and pipeline cleared, cols and rows set to 768, no input
// taken; the vector store is not cleared and holds nothing valid until loaded.
module matrix_vector_multiply #(
  parameter int MAX_COLS = 16384
) (
  input  logic       clk,
  input  logic       rst,
  mvm_in_if.sink     item_in,
  mvm_out_if.source  result,
  mvm_cfg_if.sink    cfg
);

  localparam int AW = $clog2(MAX_COLS);

  logic                               advance;
  logic                               mem_we;
  logic [AW-1:0]                      mem_waddr;
  logic                               mem_re;
  logic [AW-1:0]                      mem_raddr;
  logic signed [mvm_pkg::VALUE_W-1:0] mem_rdata;
  mvm_pkg::mvm_op_t                   op;

  assign item_in.ready = advance && !rst;
  assign cfg.ready     = !rst;

  // sequencer
  mvm_ctrl #(
    .MAX_COLS (MAX_COLS),
    .AW       (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .in_valid  (item_in.valid),
    .in_mode   (item_in.mode),
    .in_value  (item_in.value),
    .cfg_valid (cfg.valid),
    .cfg_index (cfg.index),
    .cfg_data  (cfg.data),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .op        (op)
  );

  // vector store
  mvm_vmem #(
    .AW (AW)
  ) u_vmem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (item_in.value),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // multiply-accumulate and result register
  mvm_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .op        (op),
    .xe        (mem_rdata),
    .out_ready (result.ready),
    .advance   (advance),
    .out_valid (result.valid),
    .dot       (result.dot),
    .row_index (result.row_index),
    .last_row  (result.last_row)
  );

endmodule

FILE: bench/mvm_checker.sv
// checker for the matrix-vector multiply: predicts each row's dot product and compares results
`timescale 1ns / 100ps
module mvm_checker #(
  parameter int MAX_COLS = 16384
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic                               in_mode,
  input  logic signed [mvm_pkg::VALUE_W-1:0] in_value,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic signed [mvm_pkg::DOT_W-1:0]   out_dot,
  input  logic [mvm_pkg::ROW_W-1:0]          out_row_index,
  input  logic                               out_last_row,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic [mvm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mvm_pkg::CFG_DATA_W-1:0]     cfg_data,
  output int                                 failures,
  output int                                 pending,
  output int                                 rows_checked
);

  typedef struct packed {
    logic signed [mvm_pkg::DOT_W-1:0] dot;
    logic [mvm_pkg::ROW_W-1:0]        row_index;
    logic                             last_row;
  } row_result_t;

  // predicted copy of the block's registers and state
  logic [mvm_pkg::COLS_W-1:0]         cols_reg;
  logic [mvm_pkg::ROW_W-1:0]          rows_reg;
  logic signed [mvm_pkg::VALUE_W-1:0] vector_mem [MAX_COLS];
  int unsigned                        load_ptr;
  int unsigned                        col_count;
  int unsigned                        row_count;
  logic signed [mvm_pkg::DOT_W-1:0]   row_sum;
  row_result_t                        expected_rows [$];
  int                                 fail_count = 0;
  int                                 checked_count = 0;

  // cols of zero acts as one, beyond the store acts as the store size
  function automatic int unsigned cols_in_use();
    if (cols_reg == '0) return 1;
    if (cols_reg > MAX_COLS) return MAX_COLS;
    return cols_reg;
  endfunction

  // one item: a vector load or a weight into the running row sum
  task automatic accumulate_item(input logic mode,
                                 input logic signed [mvm_pkg::VALUE_W-1:0] value);
    int unsigned nc;
    int unsigned nr;
    row_result_t row;
    nc = cols_in_use();
    nr = (rows_reg == '0) ? 1 : rows_reg;
    if (mode == mvm_pkg::MODE_LOAD) begin
      if (load_ptr >= nc) load_ptr = 0;
      vector_mem[load_ptr] = value;
      load_ptr++;
      if (load_ptr >= nc) load_ptr = 0;
      col_count = 0;
      row_count = 0;
      row_sum   = '0;
    end else begin
      load_ptr = 0;
      row_sum  = row_sum + value * vector_mem[col_count];
      col_count++;
      if (col_count >= nc) begin
        row.dot       = row_sum;
        row.row_index = mvm_pkg::ROW_W'(row_count);
        row.last_row  = (row_count >= nr - 1);
        expected_rows.push_back(row);
        row_sum   = '0;
        col_count = 0;
        row_count = row.last_row ? 0 : row_count + 1;
      end
    end
  endtask

  // watch all three channels at each edge
  always @(posedge clk) begin
    row_result_t want;
    if (rst) begin
      cols_reg  = mvm_pkg::COLS_RESET;
      rows_reg  = mvm_pkg::ROWS_RESET;
      load_ptr  = 0;
      col_count = 0;
      row_count = 0;
      row_sum   = '0;
      expected_rows.delete();
    end else begin
      // row results against the oldest prediction
      if (out_valid && out_ready) begin
        checked_count++;
        if (expected_rows.size() == 0) begin
          $display("%0t: unexpected row result: expected nothing, got row %0d dot %0d last %0b",
                   $time, out_row_index, out_dot, out_last_row);
          fail_count++;
        end else begin
          want = expected_rows.pop_front();
          if (out_dot !== want.dot) begin
            $display("%0t: row %0d dot expected %0d, got %0d", $time, want.row_index, want.dot,
                     out_dot);
            fail_count++;
          end
          if (out_row_index !== want.row_index) begin
            $display("%0t: row_index expected %0d, got %0d", $time, want.row_index,
                     out_row_index);
            fail_count++;
          end
          if (out_last_row !== want.last_row) begin
            $display("%0t: row %0d last_row expected %0b, got %0b", $time, want.row_index,
                     want.last_row, out_last_row);
            fail_count++;
          end
        end
      end
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          mvm_pkg::CFG_COLS: cols_reg = cfg_data[mvm_pkg::COLS_W-1:0];
          mvm_pkg::CFG_ROWS: rows_reg = cfg_data[mvm_pkg::ROW_W-1:0];
          default: ;
        endcase
      end
      // accepted input items
      if (in_valid && in_ready) accumulate_item(in_mode, in_value);
    end
    failures     <= fail_count;
    pending      <= expected_rows.size();
    rows_checked <= checked_count;
  end

endmodule

FILE: bench/testbench.sv
// top of the matrix-vector multiply bench: clock, reset, stimulus and verdict
`timescale 1ns / 100ps
module testbench;

  localparam int MAX_COLS     = 16384;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int RANDOM_ITEMS = 480;

  logic clk;
  logic rst;

  mvm_in_if  item_in ();
  mvm_out_if result ();
  mvm_cfg_if cfg ();

  matrix_vector_multiply #(.MAX_COLS(MAX_COLS)) dut (
    .clk     (clk),
    .rst     (rst),
    .item_in (item_in),
    .result  (result),
    .cfg     (cfg)
  );

  int failures;
  int pending;
  int rows_checked;

  mvm_checker #(.MAX_COLS(MAX_COLS)) u_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (item_in.valid),
    .in_ready      (item_in.ready),
    .in_mode       (item_in.mode),
    .in_value      (item_in.value),
    .out_valid     (result.valid),
    .out_ready     (result.ready),
    .out_dot       (result.dot),
    .out_row_index (result.row_index),
    .out_last_row  (result.last_row),
    .cfg_valid     (cfg.valid),
    .cfg_ready     (cfg.ready),
    .cfg_index     (cfg.index),
    .cfg_data      (cfg.data),
    .failures      (failures),
    .pending       (pending),
    .rows_checked  (rows_checked)
  );

  // stimulus bookkeeping: settings in force and which vector entries hold data
  int          src_idle_pct;
  int          sink_stall_pct;
  logic [15:0] cols_now;
  logic [15:0] rows_now;
  bit          written [MAX_COLS];
  int unsigned load_ptr_m;
  int unsigned prefix;
  int          items_sent;
  int          reg_writes;
  int          cycles;

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // result side backpressure
  initial begin
    result.ready <= 1'b0;
    forever begin
      @(posedge clk);
      result.ready <= !rst && ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // watchdog
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timed out after %0d cycles, %0d row results outstanding", cycles, pending);
    $display("Some tests failed");
    $finish;
  end

  task automatic set_idling(input int src_pct, input int sink_pct);
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
  endtask

  function automatic int unsigned cols_in_use();
    logic [mvm_pkg::COLS_W-1:0] c;
    c = cols_now[mvm_pkg::COLS_W-1:0];
    if (c == '0) return 1;
    if (c > MAX_COLS) return MAX_COLS;
    return c;
  endfunction

  // mostly random values, with the extremes drawn often
  function automatic logic signed [mvm_pkg::VALUE_W-1:0] next_value();
    case ($urandom_range(15))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return '0;
      3: return '1;
      default: return mvm_pkg::VALUE_W'($urandom);
    endcase
  endfunction

  // one item through the input channel, with random gaps before it
  task automatic send_item(input logic mode, input logic signed [mvm_pkg::VALUE_W-1:0] value);
    int unsigned nc;
    while ($urandom_range(99) < src_idle_pct) begin
      item_in.valid <= 1'b0;
      @(posedge clk);
    end
    item_in.valid <= 1'b1;
    item_in.mode  <= mode;
    item_in.value <= value;
    do @(posedge clk); while (!item_in.ready);
    items_sent++;
    // track loaded entries so that weights never read an empty one
    nc = cols_in_use();
    if (mode == mvm_pkg::MODE_LOAD) begin
      if (load_ptr_m >= nc) load_ptr_m = 0;
      written[load_ptr_m] = 1'b1;
      load_ptr_m++;
      if (load_ptr_m >= nc) load_ptr_m = 0;
      while (prefix < MAX_COLS && written[prefix]) prefix++;
    end else begin
      load_ptr_m = 0;
    end
  endtask

  // drain all results, then give the pipeline time to settle
  task automatic wait_idle();
    item_in.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [mvm_pkg::CFG_IDX_W-1:0] index,
                           input logic [mvm_pkg::CFG_DATA_W-1:0] data);
    wait_idle();
    cfg.valid <= 1'b1;
    cfg.index <= index;
    cfg.data  <= data;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    reg_writes++;
    if (index == mvm_pkg::CFG_COLS) cols_now = data;
    else rows_now = data;
  endtask

  // one random set: maybe new sizes, a vector, then rows of weights
  task automatic random_set();
    int unsigned nc;
    int unsigned rows_in;
    int unsigned nrows;
    int          pick;
    logic [15:0] new_cols;
    logic [15:0] new_rows;
    if ($urandom_range(1) == 0) begin
      pick     = $urandom_range(99);
      new_cols = (pick < 5) ? 16'd0 : (pick < 12) ? 16'($urandom_range(13, 40))
                                                  : 16'($urandom_range(1, 12));
      if ($urandom_range(3) == 0) new_cols[15] = 1'b1;
      new_rows = ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(1, 6));
      case ($urandom_range(2))
        0: begin
          write_reg(mvm_pkg::CFG_COLS, new_cols);
          write_reg(mvm_pkg::CFG_ROWS, new_rows);
        end
        1: write_reg(mvm_pkg::CFG_COLS, new_cols);
        default: write_reg(mvm_pkg::CFG_ROWS, new_rows);
      endcase
    end
    nc = cols_in_use();
    // vector: usually whole, sometimes short or overfilled
    pick = $urandom_range(9);
    if (pick < 8) repeat (nc) send_item(mvm_pkg::MODE_LOAD, next_value());
    else if (pick == 8) repeat ($urandom_range(0, nc)) send_item(mvm_pkg::MODE_LOAD, next_value());
    else repeat (nc + $urandom_range(1, nc)) send_item(mvm_pkg::MODE_LOAD, next_value());
    // whole rows, running past the end of a pass at times
    rows_in = (rows_now == '0) ? 1 : rows_now;
    nrows   = $urandom_range(1, 2 * rows_in + 1);
    for (int r = 0; r < nrows; r++) begin
      for (int c = 0; c < nc; c++) begin
        if (prefix < nc || items_sent >= RANDOM_ITEMS) return;
        if ($urandom_range(39) == 0) send_item(mvm_pkg::MODE_LOAD, next_value());
        else send_item(mvm_pkg::MODE_WEIGHT, next_value());
      end
    end
    // a row left unfinished
    if (prefix >= nc && $urandom_range(7) == 0)
      repeat ($urandom_range(1, nc)) send_item(mvm_pkg::MODE_WEIGHT, next_value());
  endtask

  // stimulus and verdict
  initial begin
    rst           <= 1'b1;
    item_in.valid <= 1'b0;
    item_in.mode  <= mvm_pkg::MODE_LOAD;
    item_in.value <= '0;
    cfg.valid     <= 1'b0;
    cfg.index     <= mvm_pkg::CFG_COLS;
    cfg.data      <= '0;
    cols_now   = mvm_pkg::COLS_RESET;
    rows_now   = mvm_pkg::ROWS_RESET;
    load_ptr_m = 0;
    prefix     = 0;
    items_sent = 0;
    reg_writes = 0;
    set_idling(15, 56);
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // small matrix, vector of extremes, one extra load wrapping to the start
    write_reg(mvm_pkg::CFG_COLS, 16'd4);
    write_reg(mvm_pkg::CFG_ROWS, 16'd2);
    send_item(mvm_pkg::MODE_LOAD, 16'sh7FFF);
    send_item(mvm_pkg::MODE_LOAD, 16'sh8000);
    send_item(mvm_pkg::MODE_LOAD, -16'sd1);
    send_item(mvm_pkg::MODE_LOAD, 16'sd1);
    send_item(mvm_pkg::MODE_LOAD, 16'sh1234);
    // one full pass, the second row flagged last
    repeat (4) send_item(mvm_pkg::MODE_WEIGHT, 16'sh8000);
    repeat (4) send_item(mvm_pkg::MODE_WEIGHT, 16'sh7FFF);
    // a new pass cut short by a vector load
    send_item(mvm_pkg::MODE_WEIGHT, 16'sd1);
    send_item(mvm_pkg::MODE_WEIGHT, -16'sd1);
    send_item(mvm_pkg::MODE_LOAD, 16'sh8000);
    // cols shrinks below the column count mid-row
    send_item(mvm_pkg::MODE_WEIGHT, 16'sh7FFF);
    send_item(mvm_pkg::MODE_WEIGHT, -16'sd2);
    send_item(mvm_pkg::MODE_WEIGHT, 16'sd3);
    write_reg(mvm_pkg::CFG_COLS, 16'd2);
    send_item(mvm_pkg::MODE_WEIGHT, 16'sd7);
    // rows and cols of zero
    write_reg(mvm_pkg::CFG_ROWS, 16'd0);
    write_reg(mvm_pkg::CFG_COLS, 16'd0);
    send_item(mvm_pkg::MODE_WEIGHT, 16'sh8000);
    send_item(mvm_pkg::MODE_WEIGHT, 16'sh7FFF);

    // random sets under three idling patterns
    while (items_sent < RANDOM_ITEMS) begin
      if (items_sent < 180) set_idling(15, 56);
      else if (items_sent < 330) set_idling(56, 15);
      else set_idling(0, 0);
      random_set();
    end

    // cols beyond the store: no wrap of the load pointer, then the row closed by a smaller cols
    set_idling(0, 0);
    write_reg(mvm_pkg::CFG_COLS, 16'h7FFF);
    write_reg(mvm_pkg::CFG_ROWS, 16'd3);
    send_item(mvm_pkg::MODE_WEIGHT, next_value());
    repeat (21) send_item(mvm_pkg::MODE_LOAD, next_value());
    repeat (20) send_item(mvm_pkg::MODE_WEIGHT, next_value());
    write_reg(mvm_pkg::CFG_COLS, 16'd21);
    send_item(mvm_pkg::MODE_WEIGHT, next_value());
    // tallest matrix, then rows cut below the row count mid-pass
    write_reg(mvm_pkg::CFG_COLS, 16'd1);
    write_reg(mvm_pkg::CFG_ROWS, 16'hFFFF);
    send_item(mvm_pkg::MODE_LOAD, next_value());
    repeat (12) send_item(mvm_pkg::MODE_WEIGHT, next_value());
    write_reg(mvm_pkg::CFG_ROWS, 16'd5);
    repeat (2) send_item(mvm_pkg::MODE_WEIGHT, next_value());

    // drain and settle
    wait_idle();
    repeat (10) @(posedge clk);

    $display("%0d items and %0d register writes sent, %0d row results checked",
             items_sent, reg_writes, rows_checked);
    $display("sizes from zero to beyond the vector store, 65535 rows, mid-row size changes,");
    $display("vector reloads and overfills, with and without stalls on either side");
    if (failures == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
